// ----- rtl/cmmr_pkg.sv -----
// Package: shared types, register indexes and reset values of the Manchester receiver.
package cmmr_pkg;

    // Timer width default and the fixed field widths
    localparam int TIME_BITS_DEF = 16;
    localparam int TIME_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TWO_T_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_T_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_T_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_T_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] TWO_T_LOW_RST    = 16'd900;
    localparam logic [CFG_DATA_W-1:0] TWO_T_HIGH_RST   = 16'd1100;
    localparam logic [CFG_DATA_W-1:0] ONE_T_LOW_RST    = 16'd400;
    localparam logic [CFG_DATA_W-1:0] ONE_T_HIGH_RST   = 16'd600;
    localparam logic [CFG_DATA_W-1:0] IDLE_TIMEOUT_RST = 16'd1110;

    // Input word opcodes
    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef enum logic [1:0] {
        CH_IDLE = 2'd0,
        CH_BUSY = 2'd1,
        CH_COLL = 2'd2
    } t_chan;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] two_t_low;
        logic [CFG_DATA_W-1:0] two_t_high;
        logic [CFG_DATA_W-1:0] one_t_low;
        logic [CFG_DATA_W-1:0] one_t_high;
        logic [CFG_DATA_W-1:0] idle_timeout;
    } t_cfg;

endpackage

// ----- rtl/cmmr_if.sv -----
// Interfaces: event input channel, result output channel and configuration write channel.
interface cmmr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [cmmr_pkg::TIME_W-1:0] time_now;
    logic                        level;

    modport source (output valid, output op, output time_now, output level, input ready);
    modport sink   (input valid, input op, input time_now, input level, output ready);
endinterface

interface cmmr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] chan_state;
    logic       byte_valid;
    logic [7:0] byte_out;

    modport source (output valid, output chan_state, output byte_valid, output byte_out,
                    input ready);
    modport sink   (input valid, input chan_state, input byte_valid, input byte_out,
                    output ready);
endinterface

interface cmmr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cmmr_pkg::CFG_IDX_W-1:0]  index;
    logic [cmmr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/cmmr_cfg_regs.sv -----
// Configuration register file: pulse-width windows and idle timeout.
module cmmr_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cmmr_cfg_if.sink         i_cfg,
    output cmmr_pkg::t_cfg   o_cfg
);

    cmmr_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.two_t_low    <= cmmr_pkg::TWO_T_LOW_RST;
            r_cfg.two_t_high   <= cmmr_pkg::TWO_T_HIGH_RST;
            r_cfg.one_t_low    <= cmmr_pkg::ONE_T_LOW_RST;
            r_cfg.one_t_high   <= cmmr_pkg::ONE_T_HIGH_RST;
            r_cfg.idle_timeout <= cmmr_pkg::IDLE_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cmmr_pkg::REG_TWO_T_LOW:    r_cfg.two_t_low    <= i_cfg.data;
                cmmr_pkg::REG_TWO_T_HIGH:   r_cfg.two_t_high   <= i_cfg.data;
                cmmr_pkg::REG_ONE_T_LOW:    r_cfg.one_t_low    <= i_cfg.data;
                cmmr_pkg::REG_ONE_T_HIGH:   r_cfg.one_t_high   <= i_cfg.data;
                cmmr_pkg::REG_IDLE_TIMEOUT: r_cfg.idle_timeout <= i_cfg.data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

endmodule

// ----- rtl/cmmr_core.sv -----
// Receiver core: channel state, Manchester bit decoder, byte assembly and result register.
module cmmr_core #(
    parameter int TIME_BITS = cmmr_pkg::TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cmmr_pkg::t_cfg i_cfg,
    cmmr_in_if.sink        i_in,
    cmmr_out_if.source     o_out
);

    localparam int EXT_W = TIME_BITS + cmmr_pkg::TIME_W;
    localparam int CMP_W = (TIME_BITS > cmmr_pkg::CFG_DATA_W) ? TIME_BITS : cmmr_pkg::CFG_DATA_W;

    cmmr_pkg::t_chan      r_chan, n_chan;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic                 r_bit, n_bit;
    logic [1:0]           r_short, n_short;
    logic [3:0]           r_cnt, n_cnt;
    logic [7:0]           r_shift, n_shift;
    logic                 r_out_valid;
    logic                 r_byte_valid, n_byte_valid;
    logic [7:0]           r_byte_out, n_byte_out;

    logic                 accept;
    logic [EXT_W-1:0]     now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] delta;
    logic [CMP_W-1:0]     delta_c;
    logic                 in_two_t;
    logic                 in_one_t;
    logic                 timed_out;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Keep the low TIME_BITS bits of the timestamp
    assign now_ext = EXT_W'(i_in.time_now);
    assign now_t   = now_ext[TIME_BITS-1:0];
    assign delta   = now_t - r_last;
    assign delta_c = CMP_W'(delta);

    assign in_two_t  = (delta_c > CMP_W'(i_cfg.two_t_low)) &&
                       (delta_c < CMP_W'(i_cfg.two_t_high));
    assign in_one_t  = (delta_c > CMP_W'(i_cfg.one_t_low)) &&
                       (delta_c < CMP_W'(i_cfg.one_t_high));
    assign timed_out = delta_c >= CMP_W'(i_cfg.idle_timeout);

    always_comb begin
        logic       push;
        logic [1:0] short_inc;
        logic [3:0] cnt_inc;
        logic [7:0] shifted;

        n_chan       = r_chan;
        n_last       = r_last;
        n_bit        = r_bit;
        n_short      = r_short;
        n_cnt        = r_cnt;
        n_shift      = r_shift;
        n_byte_valid = 1'b0;
        n_byte_out   = 8'd0;
        push         = 1'b0;
        short_inc    = r_short + 2'd1;

        if (i_in.op == cmmr_pkg::OP_EDGE) begin
            n_chan = cmmr_pkg::CH_BUSY;
            n_last = now_t;
            if (r_chan == cmmr_pkg::CH_IDLE) begin
                // first edge of a burst always decodes as a zero
                n_bit = 1'b0;
                push  = 1'b1;
            end else if (in_two_t) begin
                n_bit   = ~r_bit;
                n_short = 2'd0;
                push    = 1'b1;
            end else if (in_one_t) begin
                // two short pulses in a row repeat the current bit
                if (short_inc >= 2'd2) begin
                    n_short = 2'd0;
                    push    = 1'b1;
                end else begin
                    n_short = short_inc;
                end
            end
        end else if (r_chan == cmmr_pkg::CH_BUSY && timed_out) begin
            n_chan = i_in.level ? cmmr_pkg::CH_IDLE : cmmr_pkg::CH_COLL;
        end

        shifted = {r_shift[6:0], n_bit};
        cnt_inc = r_cnt + 4'd1;
        if (push) begin
            if (cnt_inc >= 4'd8) begin
                n_byte_valid = 1'b1;
                n_byte_out   = shifted;
                n_cnt        = 4'd0;
                n_shift      = 8'd0;
            end else begin
                n_cnt   = cnt_inc;
                n_shift = shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan      <= cmmr_pkg::CH_IDLE;
            r_last      <= '0;
            r_bit       <= 1'b0;
            r_short     <= 2'd0;
            r_cnt       <= 4'd0;
            r_shift     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_chan      <= n_chan;
                r_last      <= n_last;
                r_bit       <= n_bit;
                r_short     <= n_short;
                r_cnt       <= n_cnt;
                r_shift     <= n_shift;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte_valid <= n_byte_valid;
            r_byte_out   <= n_byte_out;
        end
    end

    // The channel register only moves when the result slot is free, so it is
    // always the state that belongs to the word on display.
    assign o_out.valid      = r_out_valid;
    assign o_out.chan_state = r_chan;
    assign o_out.byte_valid = r_byte_valid;
    assign o_out.byte_out   = r_byte_out;

endmodule

// ----- rtl/channel_monitor_manchester_receiver.sv -----
// Top level: channel monitor and Manchester pulse-width receiver.
//
// The receiver takes one event word per cycle unless the output stalls, and
// returns exactly one result word per event, in the cycle after acceptance,
// through a single output register. An edge word (op 0) carries the timer
// value of a captured line edge: the channel goes busy, the pulse width since
// the previous edge (modulo 2^TIME_BITS) is classed as long (2T) or short
// (1T) against the exclusive windows in the configuration registers, and the
// Manchester decoder shifts bits in most significant bit first. The first edge
// after idle always adds a zero; a long pulse flips the bit and adds it; every
// second short pulse in a row adds the current bit again; other widths add
// nothing. The result carries byte_valid and the byte on every eighth bit. A
// check word (op 1) carries the timer and line level: once idle_timeout ticks
// have passed since the last edge, a busy channel goes idle if the line is
// high and collision if it is low. Throughput is one word per cycle while the
// output is not stalled, and the input stays open while the result is being
// taken. Configuration is written through its own channel, always ready; the
// user must write it only while no word is in flight, as the block does not
// enforce this. TIME_BITS sets the timer width kept for the last edge and used
// by the width subtractor; only the low TIME_BITS bits of time_now are used.
module channel_monitor_manchester_receiver #(
    parameter int TIME_BITS = cmmr_pkg::TIME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cmmr_cfg_if.sink   i_cfg,
    cmmr_in_if.sink    i_in,
    cmmr_out_if.source o_out
);

    cmmr_pkg::t_cfg cfg;

    // Hold the windows and timeout
    cmmr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Decode events and register the result word
    cmmr_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ----- bench/testbench.sv -----
// Testbench for the channel monitor and Manchester receiver: directed script, random traffic.
module testbench;
    import cmmr_pkg::*;

    // One result word as the decoder should produce it
    typedef struct packed {
        t_chan      chan;
        logic       bv;
        logic [7:0] data;
    } t_rx_word;

    // One row of the directed script; pinned rows carry a hand-written result
    typedef struct {
        logic       op;
        logic [15:0] stamp;
        logic       lvl;
        bit         pinned;
        t_rx_word   word;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cmmr_in_if  event_ch ();
    cmmr_out_if result_ch ();
    cmmr_cfg_if reg_ch ();

    channel_monitor_manchester_receiver i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (reg_ch),
        .i_in   (event_ch),
        .o_out  (result_ch)
    );

    // Decoder mirror: line state, bit assembly and the window registers
    t_cfg        rx_cfg;
    t_chan       rx_chan;
    logic [15:0] rx_last;
    logic        rx_bit;
    logic [1:0]  rx_shorts;
    logic [3:0]  rx_nbits;
    logic [7:0]  rx_shift;

    t_rx_word    decoded_q[$];
    t_step       script[$];
    int          mismatch_cnt = 0;
    int          words_in = 0;
    bit          calm = 1'b0;
    bit          squeeze_done = 1'b0;
    logic [15:0] tcur;

    // Sideband from the sender: a pinned result for the word now on offer
    bit          pin_now;
    t_rx_word    pin_word;

    // 8-unit period, high then low
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case a handshake hangs
    initial begin
        #(8 * 600000);
        $display("[channel_monitor_manchester_receiver] ERROR");
        $finish;
    end

    task automatic flag(input string msg);
        mismatch_cnt++;
        $display("mismatch: %s", msg);
    endtask

    task automatic clear_decoder();
        rx_cfg.two_t_low    = TWO_T_LOW_RST;
        rx_cfg.two_t_high   = TWO_T_HIGH_RST;
        rx_cfg.one_t_low    = ONE_T_LOW_RST;
        rx_cfg.one_t_high   = ONE_T_HIGH_RST;
        rx_cfg.idle_timeout = IDLE_TIMEOUT_RST;
        rx_chan   = CH_IDLE;
        rx_last   = '0;
        rx_bit    = 1'b0;
        rx_shorts = '0;
        rx_nbits  = '0;
        rx_shift  = '0;
    endtask

    // Advance the decoder mirror by one event word and return its result
    task automatic decode_event(input logic op, input logic [15:0] stamp, input logic lvl,
                                output t_rx_word res);
        logic [15:0] span;
        t_chan       was;
        logic        grow;
        span     = stamp - rx_last;
        grow     = 1'b0;
        res.bv   = 1'b0;
        res.data = '0;
        if (op == OP_EDGE) begin
            was     = rx_chan;
            rx_chan = CH_BUSY;
            rx_last = stamp;
            if (was == CH_IDLE) begin
                // first edge out of idle: append a zero, width not looked at
                rx_bit = 1'b0;
                grow   = 1'b1;
            end else if (span > rx_cfg.two_t_low && span < rx_cfg.two_t_high) begin
                rx_bit    = ~rx_bit;
                rx_shorts = '0;
                grow      = 1'b1;
            end else if (span > rx_cfg.one_t_low && span < rx_cfg.one_t_high) begin
                rx_shorts = rx_shorts + 2'd1;
                if (rx_shorts >= 2'd2) begin
                    rx_shorts = '0;
                    grow      = 1'b1;
                end
            end
            if (grow) begin
                rx_shift = {rx_shift[6:0], rx_bit};
                rx_nbits = rx_nbits + 4'd1;
                if (rx_nbits >= 4'd8) begin
                    res.bv   = 1'b1;
                    res.data = rx_shift;
                    rx_nbits = '0;
                    rx_shift = '0;
                end
            end
        end else if (rx_chan == CH_BUSY && span >= rx_cfg.idle_timeout) begin
            rx_chan = lvl ? CH_IDLE : CH_COLL;
        end
        res.chan = rx_chan;
    endtask

    // Scoreboard: track register writes, predict on each accepted event word,
    // and check each accepted result word against the oldest prediction
    always @(posedge i_clk) begin : scoreboard
        t_rx_word want;
        t_rx_word seen;
        if (!i_rst_n) begin
            clear_decoder();
        end else begin
            if (reg_ch.valid && reg_ch.ready) begin
                case (reg_ch.index)
                    REG_TWO_T_LOW:    rx_cfg.two_t_low    = reg_ch.data;
                    REG_TWO_T_HIGH:   rx_cfg.two_t_high   = reg_ch.data;
                    REG_ONE_T_LOW:    rx_cfg.one_t_low    = reg_ch.data;
                    REG_ONE_T_HIGH:   rx_cfg.one_t_high   = reg_ch.data;
                    REG_IDLE_TIMEOUT: rx_cfg.idle_timeout = reg_ch.data;
                    default: ;
                endcase
            end
            // Push before pop so a same-edge result still finds its prediction
            if (event_ch.valid && event_ch.ready) begin
                decode_event(event_ch.op, event_ch.time_now, event_ch.level, want);
                if (pin_now)
                    want = pin_word;
                decoded_q.push_back(want);
                words_in++;
            end
            if (result_ch.valid && result_ch.ready) begin
                if (decoded_q.size() == 0) begin
                    flag($sformatf("result word with no event pending (state %0d byte %0d/%h)",
                                   result_ch.chan_state, result_ch.byte_valid,
                                   result_ch.byte_out));
                end else begin
                    seen = decoded_q.pop_front();
                    if (result_ch.chan_state !== seen.chan)
                        flag($sformatf("chan_state got %0d want %0d",
                                       result_ch.chan_state, seen.chan));
                    if (result_ch.byte_valid !== seen.bv)
                        flag($sformatf("byte_valid got %0d want %0d",
                                       result_ch.byte_valid, seen.bv));
                    if (result_ch.byte_out !== seen.data)
                        flag($sformatf("byte_out got %h want %h",
                                       result_ch.byte_out, seen.data));
                end
            end
        end
    end

    // Receiver: stall at random, hold off once for a long stretch, stay open when calm
    initial begin : receiver
        int r;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!squeeze_done && !calm && words_in >= 600) begin
                // hold off long enough that the output register fills and input stalls
                result_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                squeeze_done = 1'b1;
            end else if (calm) begin
                result_ch.ready <= 1'b1;
                @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    result_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 4)) @(negedge i_clk);
                end else if (r < 95) begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(negedge i_clk);
                end else begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(negedge i_clk);
                end
            end
        end
    end

    // Offer one event word and hold it until accepted; return at the next falling edge
    task automatic send_word(input logic op, input logic [15:0] stamp, input logic lvl,
                             input bit pin, input t_rx_word pinned);
        event_ch.valid    <= 1'b1;
        event_ch.op       <= op;
        event_ch.time_now <= stamp;
        event_ch.level    <= lvl;
        pin_now           <= pin;
        pin_word          <= pinned;
        @(posedge i_clk);
        while (!event_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid for a random gap, mostly none or short
    task automatic pause_input();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            n = 0;
        else if (r < 95)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0) begin
            event_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Offer one register write and hold it until accepted; valid stays up for the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= val;
        @(posedge i_clk);
        while (!reg_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write all five registers plus one index past the end, which must be ignored
    task automatic set_windows(input int two_lo, input int two_hi, input int one_lo,
                               input int one_hi, input int timeout);
        write_reg(REG_TWO_T_LOW, two_lo[15:0]);
        write_reg(REG_TWO_T_HIGH, two_hi[15:0]);
        write_reg(REG_ONE_T_LOW, one_lo[15:0]);
        write_reg(REG_ONE_T_HIGH, one_hi[15:0]);
        write_reg(REG_IDLE_TIMEOUT, timeout[15:0]);
        write_reg(REG_IDLE_TIMEOUT + 3'd1 + 3'($urandom_range(0, 2)), 16'($urandom));
        reg_ch.valid <= 1'b0;
        tcur = rx_last;
    endtask

    // Stop offering, then wait for every pending result plus the pipeline latency
    task automatic drain_results();
        int k;
        event_ch.valid <= 1'b0;
        for (k = 0; k < 5000 && decoded_q.size() != 0; k++)
            @(negedge i_clk);
        if (decoded_q.size() != 0) begin
            flag($sformatf("%0d result words never arrived", decoded_q.size()));
            decoded_q.delete();
        end
        repeat (2) @(negedge i_clk);
    endtask

    function automatic int window_pick(input int lo, input int hi);
        if (hi > lo + 1)
            return $urandom_range(lo + 1, hi - 1);
        return $urandom_range(1, 65535);
    endfunction

    // Random traffic: mostly pulse trains whose widths land in the windows,
    // with timer checks around the timeout and a share of raw noise
    task automatic random_events(input int count);
        int k;
        int r;
        int span;
        logic op;
        logic [15:0] stamp;
        for (k = 0; k < count; k++) begin
            pause_input();
            r = $urandom_range(0, 99);
            if (r < 70) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: span = window_pick(rx_cfg.two_t_low, rx_cfg.two_t_high);
                    4, 5, 6, 7: span = window_pick(rx_cfg.one_t_low, rx_cfg.one_t_high);
                    8: begin
                        case ($urandom_range(0, 3))
                            0: span = rx_cfg.two_t_low;
                            1: span = rx_cfg.two_t_high;
                            2: span = rx_cfg.one_t_low;
                            default: span = rx_cfg.one_t_high;
                        endcase
                        span = span + $urandom_range(0, 2) - 1;
                    end
                    default: span = $urandom_range(0, 65535);
                endcase
                tcur = tcur + span[15:0];
                send_word(OP_EDGE, tcur, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (r < 90) begin
                if ($urandom_range(0, 1))
                    span = rx_cfg.idle_timeout + $urandom_range(0, 3);
                else
                    span = $urandom_range(0, rx_cfg.idle_timeout);
                stamp = tcur + span[15:0];
                send_word(OP_CHECK, stamp, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
                op    = 1'($urandom_range(0, 1));
                stamp = 16'($urandom);
                if (op == OP_EDGE)
                    tcur = stamp;
                send_word(op, stamp, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end
    endtask

    task automatic add_row(input logic op, input logic [15:0] stamp, input logic lvl,
                           input bit pinned, input t_chan chan, input logic bv,
                           input logic [7:0] data);
        t_step s;
        s.op        = op;
        s.stamp     = stamp;
        s.lvl       = lvl;
        s.pinned    = pinned;
        s.word.chan = chan;
        s.word.bv   = bv;
        s.word.data = data;
        script.push_back(s);
    endtask

    initial begin : stimulus
        t_step s;
        event_ch.valid    <= 1'b0;
        event_ch.op       <= OP_EDGE;
        event_ch.time_now <= '0;
        event_ch.level    <= 1'b0;
        reg_ch.valid      <= 1'b0;
        reg_ch.index      <= '0;
        reg_ch.data       <= '0;
        pin_now           <= 1'b0;
        pin_word          <= '0;
        i_rst_n           <= 1'b0;

        // Directed script at reset windows: 2T 900..1100, 1T 400..600, timeout 1110
        add_row(OP_CHECK, 16'd0,     1'b1, 1, CH_IDLE, 1'b0, 8'h00); // check while idle
        add_row(OP_EDGE,  16'd0,     1'b0, 1, CH_BUSY, 1'b0, 8'h00); // first edge, bit 0
        add_row(OP_EDGE,  16'd1000,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // long: flip to 1
        add_row(OP_EDGE,  16'd1500,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // first short
        add_row(OP_EDGE,  16'd2000,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // second short: repeat
        add_row(OP_EDGE,  16'd2700,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // outside both windows
        add_row(OP_EDGE,  16'd3700,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // long: flip to 0
        add_row(OP_EDGE,  16'd4600,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // exactly 2T low bound
        add_row(OP_EDGE,  16'd5700,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // exactly 2T high bound
        add_row(OP_EDGE,  16'd6299,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // short just below high
        add_row(OP_EDGE,  16'd6700,  1'b0, 0, CH_BUSY, 1'b0, 8'h00); // short just above low
        add_row(OP_EDGE,  16'd7701,  1'b0, 0, CH_BUSY, 1'b0, 8'h00);
        add_row(OP_EDGE,  16'd8700,  1'b0, 0, CH_BUSY, 1'b0, 8'h00);
        add_row(OP_EDGE,  16'd9700,  1'b0, 1, CH_BUSY, 1'b1, 8'h65); // eighth bit: byte
        add_row(OP_CHECK, 16'd10809, 1'b1, 0, CH_BUSY, 1'b0, 8'h00); // one tick short
        add_row(OP_CHECK, 16'd10810, 1'b0, 1, CH_COLL, 1'b0, 8'h00); // timeout, line low
        add_row(OP_CHECK, 16'd20000, 1'b1, 1, CH_COLL, 1'b0, 8'h00); // collision holds
        add_row(OP_EDGE,  16'd21000, 1'b0, 0, CH_BUSY, 1'b0, 8'h00); // edge after collision
        add_row(OP_CHECK, 16'd22110, 1'b1, 1, CH_IDLE, 1'b0, 8'h00); // timeout, line high
        add_row(OP_EDGE,  16'd65535, 1'b1, 1, CH_BUSY, 1'b0, 8'h00); // max stamp, from idle
        add_row(OP_EDGE,  16'd999,   1'b0, 0, CH_BUSY, 1'b0, 8'h00); // width across wrap
        add_row(OP_CHECK, 16'd500,   1'b0, 1, CH_COLL, 1'b0, 8'h00); // elapsed wraps large
        add_row(OP_CHECK, 16'd65535, 1'b1, 1, CH_COLL, 1'b0, 8'h00);
        add_row(OP_EDGE,  16'd0,     1'b1, 0, CH_BUSY, 1'b0, 8'h00); // odd width, no bit

        // Hold reset, then release it at a falling edge
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[k]) begin
            s = script[k];
            pause_input();
            send_word(s.op, s.stamp, s.lvl, s.pinned, s.word);
        end
        drain_results();

        // Reset windows, random traffic
        set_windows(900, 1100, 400, 600, 1110);
        random_events(300);
        drain_results();

        // Every width but 0 and 65535 counts as long, short window empty, shortest timeout
        set_windows(0, 65535, 0, 0, 1);
        random_events(250);
        drain_results();

        // Overlapping windows (long wins), longest timeout
        set_windows(300, 700, 400, 600, 65535);
        random_events(250);
        drain_results();

        // Short bit period with no idling on either side
        set_windows(80, 120, 40, 60, 130);
        calm = 1'b1;
        random_events(300);
        drain_results();
        calm = 1'b0;

        // Long window empty, every width but 0 and 65535 counts as short
        set_windows(65535, 0, 0, 65535, 700);
        random_events(250);
        drain_results();

        // Fully random windows
        set_windows($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(1, 65535));
        random_events(350);
        drain_results();

        if (mismatch_cnt == 0)
            $display("[channel_monitor_manchester_receiver] OK");
        else
            $display("[channel_monitor_manchester_receiver] ERROR");
        $finish;
    end

endmodule
